// ===== design/sas_pkg.sv =====
// ----------------------------------------------------------------------------
// sas_pkg
// Types, constants and codes shared by the amplitude statistics block.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int MAX_BARS_DEF    = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int WSUM_W  = 48;
  localparam int WSQ_W   = 64;
  localparam int WCNT_W  = 32;
  localparam int BSUM_W  = 40;
  localparam int BCNT_W  = 24;
  localparam int DIVD_W  = 64;
  localparam int DIVS_W  = 32;
  localparam int ROOT_W  = 32;

  typedef struct packed {
    logic [15:0] sample;
    logic        last_of_bar;
    logic        last_of_window;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  bar_number;
    logic [15:0] bar_average;
    logic [15:0] window_mean;
    logic [15:0] window_std_dev;
    logic [15:0] window_min;
    logic [15:0] window_max;
    logic        last;
  } out_item_t;

  localparam logic KIND_BAR    = 1'b0;
  localparam logic KIND_WINDOW = 1'b1;

  typedef enum logic [1:0] {
    DIV_BAR,
    DIV_MEAN,
    DIV_CEIL,
    DIV_VAR
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BAR_GO,
    ST_BAR_WAIT,
    ST_BAR_OUT,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_RR,
    ST_CEIL_GO,
    ST_CEIL_WAIT,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_WIN_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic     acc;
    logic     div_start;
    div_sel_t div_sel;
    logic     mul_lo;
    logic     mul_hi;
    logic     mul_rr;
    logic     var_zero;
    logic     sqrt_start;
    logic     load_bar;
    logic     bar_last;
    logic     load_win;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic d_lt_c;
    logic out_free;
  } sts_t;

  function automatic logic [15:0] clamp16(input logic [63:0] v);
    clamp16 = (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ===== design/sas_div.sv =====
// ----------------------------------------------------------------------------
// sas_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sas_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sas_pkg::DIVD_W-1:0]  dividend,
  input  logic [sas_pkg::DIVS_W-1:0]  divisor,
  output logic                        done,
  output logic [sas_pkg::DIVD_W-1:0]  quotient,
  output logic [sas_pkg::DIVS_W-1:0]  remainder
);
  import sas_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [DIVD_W-1:0] q_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dsr_r;
  logic [DIVS_W:0]   shifted;
  logic              fits;

  assign shifted = {rem_r, q_r[DIVD_W-1]};
  assign fits    = shifted >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DIVD_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[DIVD_W-2:0], fits};
      rem_r <= fits ? DIVS_W'(shifted - {1'b0, dsr_r}) : shifted[DIVS_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("divider done held");
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> cnt_r == '0) else $error("divider done while running");
  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> cnt_r == CNT_W'(DIVD_W)) else $error("divider start lost");

endmodule

// ===== design/sas_sqrt.sv =====
// ----------------------------------------------------------------------------
// sas_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sas_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sas_pkg::DIVD_W-1:0]  radicand,
  output logic                        done,
  output logic [sas_pkg::ROOT_W-1:0]  root
);
  import sas_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [DIVD_W-1:0] v_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic              fits;

  assign rem_sh = {rem_r, v_r[DIVD_W-1:DIVD_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(ROOT_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      v_r    <= {v_r[DIVD_W-3:0], 2'b00};
      rem_r  <= fits ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== design/sas_ctrl.sv =====
// ----------------------------------------------------------------------------
// sas_ctrl
// Sequencer: accepts samples, then steps the datapath through bar and window ends.
// ----------------------------------------------------------------------------
module sas_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          ends_bar,
  input  logic          ends_window,
  output logic          in_ready,
  input  sas_pkg::sts_t sts,
  output sas_pkg::cmd_t cmd
);
  import sas_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        win_r, win_nxt;
  logic        accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      win_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
    end
  end

  assign win_nxt = accept ? ends_window : win_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (accept && (ends_bar || ends_window)) state_nxt = ST_BAR_GO;
      ST_BAR_GO:    state_nxt = ST_BAR_WAIT;
      ST_BAR_WAIT:  if (sts.div_done) state_nxt = ST_BAR_OUT;
      ST_BAR_OUT:   if (sts.out_free) state_nxt = win_r ? ST_MEAN_GO : ST_IDLE;
      ST_MEAN_GO:   state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (sts.div_done) state_nxt = ST_MUL_LO;
      ST_MUL_LO:    state_nxt = ST_MUL_HI;
      ST_MUL_HI:    state_nxt = ST_MUL_RR;
      ST_MUL_RR:    state_nxt = ST_CEIL_GO;
      ST_CEIL_GO:   state_nxt = ST_CEIL_WAIT;
      ST_CEIL_WAIT: if (sts.div_done) state_nxt = ST_VAR_GO;
      ST_VAR_GO:    state_nxt = sts.d_lt_c ? ST_SQRT_GO : ST_VAR_WAIT;
      ST_VAR_WAIT:  if (sts.div_done) state_nxt = ST_SQRT_GO;
      ST_SQRT_GO:   state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sts.sqrt_done) state_nxt = ST_WIN_OUT;
      ST_WIN_OUT:   if (sts.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_BAR;
    cmd.acc     = accept;
    unique case (state_r)
      ST_BAR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_BAR;
      end
      ST_BAR_OUT: begin
        cmd.load_bar = sts.out_free;
        // a window end follows the bar result with a second one
        cmd.bar_last = !win_r;
      end
      ST_MEAN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
      end
      ST_MUL_LO:   cmd.mul_lo = 1'b1;
      ST_MUL_HI:   cmd.mul_hi = 1'b1;
      ST_MUL_RR:   cmd.mul_rr = 1'b1;
      ST_CEIL_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CEIL;
      end
      ST_VAR_GO: begin
        // deviation below the rounding term floors to zero
        cmd.var_zero  = sts.d_lt_c;
        cmd.div_start = !sts.d_lt_c;
        cmd.div_sel   = DIV_VAR;
      end
      ST_SQRT_GO:  cmd.sqrt_start = 1'b1;
      ST_WIN_OUT:  cmd.load_win = sts.out_free;
      default: begin
      end
    endcase
  end

  a_bar_end_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (ends_bar || ends_window)) |=> state_r == ST_BAR_GO)
    else $error("bar end not followed by division");
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_bar || cmd.load_win) |-> sts.out_free)
    else $error("result loaded over a waiting one");
  a_win_only_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MEAN_GO) |-> win_r)
    else $error("window statistics without window end");

endmodule

// ===== design/sas_dp.sv =====
// ----------------------------------------------------------------------------
// sas_dp
// Accumulators, shared divider, multiplier steps, square root and result register.
// ----------------------------------------------------------------------------
module sas_dp #(
  parameter int MAX_BARS    = sas_pkg::MAX_BARS_DEF,
  parameter int SAMPLE_BITS = sas_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sas_pkg::cmd_t      cmd,
  output sas_pkg::sts_t      sts,
  input  logic [15:0]        sample,
  input  logic               out_ready,
  output logic               out_valid,
  output sas_pkg::out_item_t out_data
);
  import sas_pkg::*;

  localparam int SB = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
  localparam logic [15:0] SAMPLE_MASK = 16'((32'(1) << SB) - 1);
  localparam int BIDX_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam logic [BIDX_W-1:0] BIDX_LAST = BIDX_W'(MAX_BARS - 1);

  logic [WSUM_W-1:0] wsum_r;
  logic [WSQ_W-1:0]  wsq_r;
  logic [WCNT_W-1:0] wcnt_r;
  logic [BSUM_W-1:0] bsum_r;
  logic [BCNT_W-1:0] bcnt_r;
  logic [BIDX_W-1:0] bidx_r;
  logic [15:0]       low_r, high_r;

  logic [15:0] x;
  logic [31:0] sq;
  logic [WSQ_W:0] sq_sum;

  assign x      = sample & SAMPLE_MASK;
  assign sq     = x * x;
  assign sq_sum = {1'b0, wsq_r} + {33'b0, sq};

  // division and root working registers
  div_sel_t    sel_r;
  logic [15:0] m_r;
  logic [31:0] r_r;
  logic [40:0] plo_r;
  logic [39:0] phi_r;
  logic [63:0] rr_r;
  logic [63:0] d_r;
  logic [63:0] c_r;
  logic [63:0] var_r;
  logic [15:0] bavg_r;
  logic [15:0] mean_r;

  logic [48:0] t_sum;
  assign t_sum = {1'b0, wsum_r} + {17'b0, r_r};

  logic              div_start;
  logic [DIVD_W-1:0] div_dvd;
  logic [DIVS_W-1:0] div_dsr;
  logic              div_done;
  logic [DIVD_W-1:0] div_q;
  logic [DIVS_W-1:0] div_rem;

  assign div_start = cmd.div_start;

  always_comb begin
    div_dsr = wcnt_r;
    unique case (cmd.div_sel)
      DIV_BAR: begin
        div_dvd = {24'b0, bsum_r};
        div_dsr = {8'b0, bcnt_r};
      end
      DIV_MEAN: div_dvd = {16'b0, wsum_r};
      DIV_CEIL: div_dvd = rr_r + {32'b0, wcnt_r} - 64'd1;
      DIV_VAR:  div_dvd = d_r - c_r;
      default:  div_dvd = '0;
    endcase
  end

  sas_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  logic              sqrt_done;
  logic [ROOT_W-1:0] root;

  sas_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (var_r),
    .done     (sqrt_done),
    .root     (root)
  );

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_win) begin
      wsum_r <= '0;
      wsq_r  <= '0;
      wcnt_r <= '0;
      bsum_r <= '0;
      bcnt_r <= '0;
      bidx_r <= '0;
      low_r  <= 16'hFFFF;
      high_r <= '0;
    end else if (cmd.acc) begin
      if (wcnt_r != '1) begin
        wcnt_r <= wcnt_r + 1'b1;
        wsum_r <= wsum_r + {32'b0, x};
        wsq_r  <= sq_sum[WSQ_W] ? '1 : sq_sum[WSQ_W-1:0];
      end
      if (bcnt_r != '1) begin
        bcnt_r <= bcnt_r + 1'b1;
        bsum_r <= bsum_r + {24'b0, x};
      end
      if (x < low_r)  low_r  <= x;
      if (x > high_r) high_r <= x;
    end else if (cmd.load_bar) begin
      bsum_r <= '0;
      bcnt_r <= '0;
      bidx_r <= (bidx_r == BIDX_LAST) ? '0 : bidx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) sel_r <= cmd.div_sel;
    if (div_done) begin
      unique case (sel_r)
        DIV_BAR:  bavg_r <= clamp16(div_q);
        DIV_MEAN: begin
          m_r    <= div_q[15:0];
          r_r    <= div_rem;
          mean_r <= clamp16(div_q);
        end
        DIV_CEIL: c_r   <= div_q;
        DIV_VAR:  var_r <= div_q;
        default: begin
        end
      endcase
    end
    if (cmd.var_zero) var_r <= '0;
    // m * (s + r) in two partial products, then r * r
    if (cmd.mul_lo) plo_r <= 41'(m_r * t_sum[24:0]);
    if (cmd.mul_hi) phi_r <= 40'(m_r * t_sum[48:25]);
    if (cmd.mul_rr) begin
      rr_r <= r_r * r_r;
      d_r  <= wsq_r - {23'b0, plo_r} - {phi_r[38:0], 25'b0};
    end
  end

  // result register
  logic      ovalid_r;
  out_item_t odata_r;
  out_item_t odata_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.load_bar || cmd.load_win) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_comb begin
    odata_nxt = '0;
    if (cmd.load_win) begin
      odata_nxt.kind           = KIND_WINDOW;
      odata_nxt.window_mean    = mean_r;
      odata_nxt.window_std_dev = clamp16({32'b0, root});
      odata_nxt.window_min     = low_r;
      odata_nxt.window_max     = high_r;
      odata_nxt.last           = 1'b1;
    end else begin
      odata_nxt.kind        = KIND_BAR;
      odata_nxt.bar_number  = 8'(bidx_r);
      odata_nxt.bar_average = bavg_r;
      odata_nxt.last        = cmd.bar_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_bar || cmd.load_win) odata_r <= odata_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.d_lt_c    = d_r < c_r;
  assign sts.out_free  = !ovalid_r || out_ready;

endmodule

// ===== design/segmented_amplitude_statistics.sv =====
// ----------------------------------------------------------------------------
// segmented_amplitude_statistics
// Running mean, deviation, minimum and maximum over a window, with bar averages.
// ----------------------------------------------------------------------------
// A sample that ends no bar leaves the sequencer idle, so the block stays ready
// for the next sample. A bar end takes one pass of the shared divider, which
// gives one quotient bit a cycle (64 steps). A window end adds further passes
// of that divider (mean, rounding term, and variance unless the deviation is
// below the rounding term), three multiplier steps and 32 steps of the square
// root unit. Input is taken only while the sequencer is idle; a finished result
// waits in the output register, and the next result waits until it is taken.
module segmented_amplitude_statistics #(
  parameter int MAX_BARS    = sas_pkg::MAX_BARS_DEF,
  parameter int SAMPLE_BITS = sas_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sas_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sas_pkg::out_item_t out_data
);
  import sas_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sas_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .ends_bar    (in_data.last_of_bar),
    .ends_window (in_data.last_of_window),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  sas_dp #(
    .MAX_BARS    (MAX_BARS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (in_data.sample),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
